/* design/cfp_pkg.sv */
// cfp_pkg: shared types and constants for the command frame parser.
// Holds the parser phase encoding, status codes and frame delimiter bytes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_U       = 4'd1,
    PH_ADDR    = 4'd2,
    PH_COMMA   = 4'd3,
    PH_LEN     = 4'd4,
    PH_HCOLON  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_TCOLON  = 4'd7,
    PH_SUM     = 4'd8,
    PH_CR      = 4'd9,
    PH_DRAIN   = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_OK     = 3'd1,
    ST_COMMA  = 3'd2,
    ST_HCOLON = 3'd3,
    ST_TCOLON = 3'd4,
    ST_SUM    = 3'd5,
    ST_CR     = 3'd6,
    ST_LEN    = 3'd7
  } status_t;

  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int unsigned ADDR_BYTES = 4;
  localparam int unsigned LEN_BYTES  = 2;

endpackage : cfp_pkg

`default_nettype wire

/* design/cfp_store.sv */
// cfp_store: payload buffer, one write port and one registered read port.
// Read data is registered and appears in the cycle after the address. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cfp_store #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output      logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : cfp_store

`default_nettype wire

/* design/command_frame_parser.sv */
// command_frame_parser: byte-wise frame parser with payload buffer and drain sequencer.
// Accepted bytes (bar a payload frame's CR) give a status transaction from the output register next cycle.
// A good frame of N payload bytes: after CR the input stalls while the buffer, with registered
// read, drains one result per cycle unless out_stall holds (N results, last one marked).
// Other bytes: one byte per cycle, limited only by the output register draining.
// Reset (rst_n, synchronous) returns to waiting for an opcode; the buffer is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module command_frame_parser #(
  parameter int unsigned PAYLOAD_DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [7:0]  in_rx_byte,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [2:0]  out_status,
  output      logic [7:0]  out_opcode,
  output      logic [31:0] out_address,
  output      logic [5:0]  out_payload_length,
  output      logic [7:0]  out_data_byte,
  output      logic [4:0]  out_data_index,
  output      logic        out_last
);

  localparam int unsigned AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PAYLOAD_DEPTH + 1);
  localparam logic [15:0] DEPTH16 = 16'(PAYLOAD_DEPTH);

  cfp_pkg::phase_t phase_r, phase_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    op_r, op_nxt;
  logic [31:0]   addr_r, addr_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          q_ok_r, q_ok_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [7:0]    oop_r, oop_nxt;
  logic [31:0]   oaddr_r, oaddr_nxt;
  logic [5:0]    olen_r, olen_nxt;
  logic [7:0]    odata_r, odata_nxt;
  logic [4:0]    oidx_r, oidx_nxt;
  logic          olast_r, olast_nxt;

  logic          out_free;
  logic          in_acc;
  logic [7:0]    b;
  logic [7:0]    sum_add;
  logic [15:0]   cnt_inc16;
  logic [15:0]   len_full;
  logic [15:0]   idx16;
  logic          drain_last;
  logic          advance;

  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  assign out_free   = !out_valid_r || !out_stall;
  assign in_stall   = (phase_r == cfp_pkg::PH_DRAIN) || !out_free;
  assign in_acc     = in_valid && !in_stall;
  assign b          = in_rx_byte;
  assign sum_add    = sum_r + b;
  assign cnt_inc16  = 16'(cnt_r) + 16'd1;
  assign len_full   = {b, len_r[7:0]};
  assign idx16      = 16'(idx_r);
  assign drain_last = (idx16 + 16'd1) == len_r;
  assign advance    = (phase_r == cfp_pkg::PH_DRAIN) && q_ok_r && out_free;
  assign wr_en      = in_acc && (phase_r == cfp_pkg::PH_PAYLOAD);

  // read the next entry ahead so the drain sustains one transaction per cycle while out_stall is low
  always_comb begin
    if (phase_r != cfp_pkg::PH_DRAIN) begin
      rd_addr = '0;
    end else if (advance && !drain_last) begin
      rd_addr = idx_r + AW'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  cfp_store #(
    .DEPTH (PAYLOAD_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data (b),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      cfp_pkg::PH_IDLE: begin
        if (in_acc && (b == cfp_pkg::CH_G || b == cfp_pkg::CH_N)) begin
          phase_nxt = cfp_pkg::PH_U;
        end
      end
      cfp_pkg::PH_U: begin
        if (in_acc) begin
          phase_nxt = (b == cfp_pkg::CH_U) ? cfp_pkg::PH_ADDR : cfp_pkg::PH_IDLE;
        end
      end
      cfp_pkg::PH_ADDR: begin
        if (in_acc && cnt_inc16 >= 16'(cfp_pkg::ADDR_BYTES)) begin
          phase_nxt = cfp_pkg::PH_COMMA;
        end
      end
      cfp_pkg::PH_COMMA: begin
        if (in_acc) begin
          phase_nxt = (b == cfp_pkg::CH_COMMA) ? cfp_pkg::PH_LEN : cfp_pkg::PH_IDLE;
        end
      end
      cfp_pkg::PH_LEN: begin
        if (in_acc && cnt_inc16 >= 16'(cfp_pkg::LEN_BYTES)) begin
          phase_nxt = (len_full > DEPTH16) ? cfp_pkg::PH_IDLE : cfp_pkg::PH_HCOLON;
        end
      end
      cfp_pkg::PH_HCOLON: begin
        if (in_acc) begin
          if (b != cfp_pkg::CH_COLON) begin
            phase_nxt = cfp_pkg::PH_IDLE;
          end else if (len_r == 16'd0) begin
            phase_nxt = cfp_pkg::PH_TCOLON;
          end else begin
            phase_nxt = cfp_pkg::PH_PAYLOAD;
          end
        end
      end
      cfp_pkg::PH_PAYLOAD: begin
        if (in_acc && cnt_inc16 >= len_r) begin
          phase_nxt = cfp_pkg::PH_TCOLON;
        end
      end
      cfp_pkg::PH_TCOLON: begin
        if (in_acc) begin
          phase_nxt = (b == cfp_pkg::CH_COLON) ? cfp_pkg::PH_SUM : cfp_pkg::PH_IDLE;
        end
      end
      cfp_pkg::PH_SUM: begin
        if (in_acc) begin
          phase_nxt = (b == sum_r) ? cfp_pkg::PH_CR : cfp_pkg::PH_IDLE;
        end
      end
      cfp_pkg::PH_CR: begin
        if (in_acc) begin
          phase_nxt = (b == cfp_pkg::CH_CR && len_r != 16'd0) ?
                      cfp_pkg::PH_DRAIN : cfp_pkg::PH_IDLE;
        end
      end
      cfp_pkg::PH_DRAIN: begin
        if (advance && drain_last) begin
          phase_nxt = cfp_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = cfp_pkg::PH_IDLE;
      end
    endcase
  end

  // datapath and output register
  always_comb begin
    cnt_nxt       = cnt_r;
    sum_nxt       = sum_r;
    op_nxt        = op_r;
    addr_nxt      = addr_r;
    len_nxt       = len_r;
    idx_nxt       = idx_r;
    q_ok_nxt      = (phase_r == cfp_pkg::PH_DRAIN) && !(advance && drain_last);
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    oop_nxt       = oop_r;
    oaddr_nxt     = oaddr_r;
    olen_nxt      = olen_r;
    odata_nxt     = odata_r;
    oidx_nxt      = oidx_r;
    olast_nxt     = olast_r;

    if (in_acc) begin
      out_valid_nxt = 1'b1;
      status_nxt    = cfp_pkg::ST_NONE;
      oop_nxt       = '0;
      oaddr_nxt     = '0;
      olen_nxt      = '0;
      odata_nxt     = '0;
      oidx_nxt      = '0;
      olast_nxt     = 1'b1;
    end

    case (phase_r)
      cfp_pkg::PH_IDLE: begin
        if (in_acc && (b == cfp_pkg::CH_G || b == cfp_pkg::CH_N)) begin
          op_nxt   = b;
          addr_nxt = '0;
          len_nxt  = '0;
          cnt_nxt  = '0;
          sum_nxt  = '0;
        end
      end
      cfp_pkg::PH_U: begin
        if (in_acc) begin
          cnt_nxt = '0;
          sum_nxt = '0;
        end
      end
      cfp_pkg::PH_ADDR: begin
        if (in_acc) begin
          addr_nxt[8*cnt_r[1:0] +: 8] = b;
          sum_nxt = sum_add;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      cfp_pkg::PH_COMMA: begin
        if (in_acc) begin
          sum_nxt = sum_add;
          cnt_nxt = '0;
          if (b != cfp_pkg::CH_COMMA) begin
            status_nxt = cfp_pkg::ST_COMMA;
          end
        end
      end
      cfp_pkg::PH_LEN: begin
        if (in_acc) begin
          if (cnt_r[0]) begin
            len_nxt[15:8] = b;
          end else begin
            len_nxt[7:0] = b;
          end
          sum_nxt = sum_add;
          cnt_nxt = cnt_r + CW'(1);
          if (cnt_inc16 >= 16'(cfp_pkg::LEN_BYTES) && len_full > DEPTH16) begin
            status_nxt = cfp_pkg::ST_LEN;
          end
        end
      end
      cfp_pkg::PH_HCOLON: begin
        if (in_acc) begin
          sum_nxt = sum_add;
          cnt_nxt = '0;
          if (b != cfp_pkg::CH_COLON) begin
            status_nxt = cfp_pkg::ST_HCOLON;
          end
        end
      end
      cfp_pkg::PH_PAYLOAD: begin
        if (in_acc) begin
          sum_nxt = sum_add;
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      cfp_pkg::PH_TCOLON: begin
        if (in_acc) begin
          sum_nxt = sum_add;
          if (b != cfp_pkg::CH_COLON) begin
            status_nxt = cfp_pkg::ST_TCOLON;
          end
        end
      end
      cfp_pkg::PH_SUM: begin
        if (in_acc && b != sum_r) begin
          status_nxt = cfp_pkg::ST_SUM;
        end
      end
      cfp_pkg::PH_CR: begin
        if (in_acc) begin
          idx_nxt = '0;
          if (b != cfp_pkg::CH_CR) begin
            status_nxt = cfp_pkg::ST_CR;
          end else if (len_r == 16'd0) begin
            status_nxt = cfp_pkg::ST_OK;
            oop_nxt    = op_r;
            oaddr_nxt  = addr_r;
          end else begin
            // hold the transaction back; the drain emits the payload
            out_valid_nxt = out_valid_r && out_stall;
          end
        end
      end
      cfp_pkg::PH_DRAIN: begin
        if (advance) begin
          out_valid_nxt = 1'b1;
          status_nxt    = cfp_pkg::ST_OK;
          oop_nxt       = op_r;
          oaddr_nxt     = addr_r;
          olen_nxt      = len_r[5:0];
          odata_nxt     = rd_data;
          oidx_nxt      = idx16[4:0];
          olast_nxt     = drain_last;
          if (!drain_last) begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= cfp_pkg::PH_IDLE;
      q_ok_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      q_ok_r      <= q_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    sum_r    <= sum_nxt;
    op_r     <= op_nxt;
    addr_r   <= addr_nxt;
    len_r    <= len_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    oop_r    <= oop_nxt;
    oaddr_r  <= oaddr_nxt;
    olen_r   <= olen_nxt;
    odata_r  <= odata_nxt;
    oidx_r   <= oidx_nxt;
    olast_r  <= olast_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_opcode         = oop_r;
  assign out_address        = oaddr_r;
  assign out_payload_length = olen_r;
  assign out_data_byte      = odata_r;
  assign out_data_index     = oidx_r;
  assign out_last           = olast_r;

  a_drain_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == cfp_pkg::PH_DRAIN) |-> (idx16 < len_r && len_r <= DEPTH16))
    else $error("drain index beyond frame length");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == cfp_pkg::PH_PAYLOAD) |-> (16'(cnt_r) < len_r && len_r <= DEPTH16))
    else $error("payload write beyond buffer");

  a_read_ready_only_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    q_ok_r |-> (phase_r == cfp_pkg::PH_DRAIN))
    else $error("read data flagged outside drain");

  a_drain_entry_waits: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == cfp_pkg::PH_CR) && (phase_nxt == cfp_pkg::PH_DRAIN)) |=> !advance)
    else $error("drain advanced before buffer read returned");

  a_frame_ok_last: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && drain_last) |=> (out_valid && out_last && phase_r == cfp_pkg::PH_IDLE))
    else $error("final payload transaction not marked last");

endmodule : command_frame_parser

`default_nettype wire
